[rtl/ptw_pkg.sv]
`default_nettype none

package ptw_pkg;

  localparam int STORE_PAGES_DEF  = 8;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int PTE_W_BITS       = 64;

  // Packed widths of the stream payloads, rounded up to whole bytes.
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 128;

  localparam logic [2:0] OP_WRITE_WORD = 3'd0;
  localparam logic [2:0] OP_LOOKUP     = 3'd1;
  localparam logic [2:0] OP_TR_READ    = 3'd2;
  localparam logic [2:0] OP_TR_WRITE   = 3'd3;
  localparam logic [2:0] OP_MAP        = 3'd4;
  localparam logic [2:0] OP_UNMAP      = 3'd5;

  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_ADDR_HIGH   = 3'd1;
  localparam logic [2:0] STS_NOT_MAPPED  = 3'd2;
  localparam logic [2:0] STS_PERM_DENIED = 3'd3;
  localparam logic [2:0] STS_REMAP       = 3'd4;
  localparam logic [2:0] STS_TABLE_OOB   = 3'd5;

  localparam int PTE_V_BIT = 0;
  localparam int PTE_W_BIT = 2;
  localparam int PTE_U_BIT = 4;
  localparam int PPN_LSB   = 10;
  localparam int PPN_MSB   = 53;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/ptw_ram.sv]
`default_nettype none

module ptw_ram #(
  parameter int WIDTH = ptw_pkg::PTE_W_BITS,
  parameter int DEPTH = ptw_pkg::STORE_PAGES_DEF * ptw_pkg::ENTRIES_PER_PAGE
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/sv39_page_table_walker_unit.sv]
// Sv39 page-table walker over an on-chip store of STORE_PAGES pages of 512 PTE words. After
// reset the block zeroes the store, one word per cycle, and holds in_tready low meanwhile;
// root_page may be written during that pass. Each accepted transaction yields exactly one
// result transaction. A write-word, an unused opcode or an address that fails before the
// walk goes from acceptance straight to the result stage; a full walk passes acceptance,
// three dependent table reads and the result stage, since every level waits on the
// previous level's registered read from the store. Map and unmap write the leaf back in
// the cycle that reads it, so no later access can overlap. A new transaction is accepted
// while a result still waits on out_tready.
`default_nettype none

module sv39_page_table_walker_unit #(
  parameter int STORE_PAGES = ptw_pkg::STORE_PAGES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [2:0]                       cfg_wr_data,   // root_page
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // opcode[2:0], virt_addr[41:3], phys_page[85:42], permissions[89:86],
  // store_page[92:90], store_index[101:93], store_data[165:102], zero fill
  input  wire logic [ptw_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // status[2:0], phys_addr[58:3], leaf_entry[122:59], zero fill
  output logic      [ptw_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int DEPTH = STORE_PAGES * ptw_pkg::ENTRIES_PER_PAGE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
  localparam logic [43:0]   PAGE_LIMIT = 44'(STORE_PAGES);
  localparam logic [AW-1:0] CLR_LAST   = AW'(DEPTH - 1);

  // Input fields.
  logic [2:0]  in_opcode;
  logic [38:0] in_virt_addr;
  logic [43:0] in_phys_page;
  logic [3:0]  in_permissions;
  logic [2:0]  in_store_page;
  logic [8:0]  in_store_index;
  logic [63:0] in_store_data;

  assign in_opcode      = in_tdata[2:0];
  assign in_virt_addr   = in_tdata[41:3];
  assign in_phys_page   = in_tdata[85:42];
  assign in_permissions = in_tdata[89:86];
  assign in_store_page  = in_tdata[92:90];
  assign in_store_index = in_tdata[101:93];
  assign in_store_data  = in_tdata[165:102];

  ptw_pkg::state_t state_r, state_nxt;
  logic [1:0]    lvl_r, lvl_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [37:0]   va_r, va_nxt;
  logic [43:0]   ppage_r, ppage_nxt;
  logic [3:0]    perm_r, perm_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [2:0]    root_page_r;
  logic [2:0]    res_status_r, res_status_nxt;
  logic [55:0]   res_pa_r, res_pa_nxt;
  logic [63:0]   res_leaf_r, res_leaf_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [ptw_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, rd_data;

  logic          in_fire, out_free;
  logic          root_oob, store_oob, walk_op, start_walk;
  logic          rd_v, rd_w, rd_u, ppn_oob, walk_fail;
  logic [43:0]   rd_ppn;
  logic [8:0]    next_idx;
  logic [PW+8:0] root_full, store_full, next_full;
  logic [AW-1:0] root_addr, store_addr, next_addr;

  assign in_tready = (state_r == ptw_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign root_oob  = (44'(root_page_r) >= PAGE_LIMIT);
  assign store_oob = (44'(in_store_page) >= PAGE_LIMIT);
  assign walk_op   = (in_opcode == ptw_pkg::OP_LOOKUP) || (in_opcode == ptw_pkg::OP_TR_READ) ||
                     (in_opcode == ptw_pkg::OP_TR_WRITE) || (in_opcode == ptw_pkg::OP_MAP) ||
                     (in_opcode == ptw_pkg::OP_UNMAP);
  assign start_walk = walk_op && !in_virt_addr[38] && !root_oob;

  assign rd_v      = rd_data[ptw_pkg::PTE_V_BIT];
  assign rd_w      = rd_data[ptw_pkg::PTE_W_BIT];
  assign rd_u      = rd_data[ptw_pkg::PTE_U_BIT];
  assign rd_ppn    = rd_data[ptw_pkg::PPN_MSB:ptw_pkg::PPN_LSB];
  assign ppn_oob   = (rd_ppn >= PAGE_LIMIT);
  assign walk_fail = (lvl_r != 2'd0) && (!rd_v || ppn_oob);

  // The level counter names the table whose entry is arriving on rd_data.
  assign next_idx   = (lvl_r == 2'd2) ? va_r[29:21] : va_r[20:12];
  assign root_full  = {PW'(root_page_r), in_virt_addr[38:30]};
  assign store_full = {PW'(in_store_page), in_store_index};
  assign next_full  = {PW'(rd_ppn), next_idx};
  assign root_addr  = root_full[AW-1:0];
  assign store_addr = store_full[AW-1:0];
  assign next_addr  = next_full[AW-1:0];

  ptw_ram #(
    .WIDTH (ptw_pkg::PTE_W_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptw_pkg::ST_CLEAR: begin
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ptw_pkg::ST_IDLE;
        end
      end
      ptw_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = start_walk ? ptw_pkg::ST_WALK : ptw_pkg::ST_DONE;
        end
      end
      ptw_pkg::ST_WALK: begin
        if ((lvl_r == 2'd0) || walk_fail) begin
          state_nxt = ptw_pkg::ST_DONE;
        end
      end
      ptw_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ptw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ptw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = slot_r;
    ram_wdata      = '0;
    ram_raddr      = slot_r;
    lvl_nxt        = lvl_r;
    op_nxt         = op_r;
    va_nxt         = va_r;
    ppage_nxt      = ppage_r;
    perm_nxt       = perm_r;
    slot_nxt       = slot_r;
    clr_cnt_nxt    = clr_cnt_r;
    res_status_nxt = res_status_r;
    res_pa_nxt     = res_pa_r;
    res_leaf_nxt   = res_leaf_r;

    case (state_r)
      ptw_pkg::ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      ptw_pkg::ST_IDLE: begin
        ram_raddr = root_addr;
        if (in_fire) begin
          op_nxt         = in_opcode;
          va_nxt         = in_virt_addr[37:0];
          ppage_nxt      = in_phys_page;
          perm_nxt       = in_permissions;
          slot_nxt       = root_addr;
          lvl_nxt        = 2'd2;
          res_status_nxt = ptw_pkg::STS_OK;
          res_pa_nxt     = '0;
          res_leaf_nxt   = '0;
          if (in_opcode == ptw_pkg::OP_WRITE_WORD) begin
            if (store_oob) begin
              res_status_nxt = ptw_pkg::STS_TABLE_OOB;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = store_addr;
              ram_wdata = in_store_data;
            end
          end else if (walk_op) begin
            if (in_virt_addr[38]) begin
              res_status_nxt = ptw_pkg::STS_ADDR_HIGH;
            end else if (root_oob) begin
              res_status_nxt = ptw_pkg::STS_TABLE_OOB;
            end
          end
        end
      end
      ptw_pkg::ST_WALK: begin
        if (lvl_r != 2'd0) begin
          if (!rd_v) begin
            res_status_nxt = ptw_pkg::STS_NOT_MAPPED;
          end else if (ppn_oob) begin
            res_status_nxt = ptw_pkg::STS_TABLE_OOB;
          end else begin
            ram_raddr = next_addr;
            slot_nxt  = next_addr;
            lvl_nxt   = lvl_r - 2'd1;
          end
        end else begin
          res_leaf_nxt = rd_data;
          case (op_r)
            ptw_pkg::OP_LOOKUP: begin
              res_pa_nxt = {rd_ppn, va_r[11:0]};
            end
            ptw_pkg::OP_TR_READ, ptw_pkg::OP_TR_WRITE: begin
              if (!rd_v) begin
                res_status_nxt = ptw_pkg::STS_NOT_MAPPED;
              end else if (!rd_u || ((op_r == ptw_pkg::OP_TR_WRITE) && !rd_w)) begin
                res_status_nxt = ptw_pkg::STS_PERM_DENIED;
              end else begin
                res_pa_nxt = {rd_ppn, va_r[11:0]};
              end
            end
            ptw_pkg::OP_MAP: begin
              if (rd_v && (rd_ppn != ppage_r)) begin
                res_status_nxt = ptw_pkg::STS_REMAP;
              end else begin
                ram_we       = 1'b1;
                ram_wdata    = {10'd0, ppage_r, 5'd0, perm_r, 1'b1};
                res_leaf_nxt = {10'd0, ppage_r, 5'd0, perm_r, 1'b1};
                res_pa_nxt   = {ppage_r, va_r[11:0]};
              end
            end
            ptw_pkg::OP_UNMAP: begin
              if (!rd_v) begin
                res_status_nxt = ptw_pkg::STS_NOT_MAPPED;
              end else begin
                ram_we = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ptw_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    if ((state_r == ptw_pkg::ST_DONE) && out_free) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {5'd0, res_leaf_r, res_pa_r, res_status_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptw_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      root_page_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        root_page_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r        <= lvl_nxt;
    op_r         <= op_nxt;
    va_r         <= va_nxt;
    ppage_r      <= ppage_nxt;
    perm_r       <= perm_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_pa_r     <= res_pa_nxt;
    res_leaf_r   <= res_leaf_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_walk_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptw_pkg::ST_WALK) |-> (lvl_r != 2'd3))
    else $error("walk level counter out of range");

  a_walk_write_leaf_only: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r == ptw_pkg::ST_WALK)) |->
      ((lvl_r == 2'd0) && ((op_r == ptw_pkg::OP_MAP) || (op_r == ptw_pkg::OP_UNMAP))))
    else $error("store written during walk other than leaf map or unmap");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=>
      ((state_r == ptw_pkg::ST_WALK) || (state_r == ptw_pkg::ST_DONE)))
    else $error("accepted transaction did not start processing");

  a_done_emits_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ptw_pkg::ST_DONE) && (state_nxt == ptw_pkg::ST_IDLE)) |=> out_tvalid_r)
    else $error("finished transaction produced no result");

endmodule

`default_nettype wire

[tb/sv/sv39_page_table_walker_unit_test.sv]
module sv39_page_table_walker_unit_test;

  localparam int N_PAGES = ptw_pkg::STORE_PAGES_DEF;
  localparam int N_WORDS = N_PAGES * ptw_pkg::ENTRIES_PER_PAGE;

  // Field order follows the in_tdata layout, lowest field last.
  typedef struct packed {
    logic [63:0] sdata;
    logic [8:0]  sidx;
    logic [2:0]  spage;
    logic [3:0]  perm;
    logic [43:0] ppn;
    logic [38:0] va;
    logic [2:0]  op;
  } walk_req_t;

  typedef struct packed {
    logic [63:0] leaf;
    logic [55:0] pa;
    logic [2:0]  status;
  } walk_rsp_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [2:0]                     cfg_wr_data;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [ptw_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [ptw_pkg::OUT_DATA_W-1:0] out_tdata;

  logic [63:0] page_store [0:N_WORDS-1];
  logic [2:0]  root_sel;
  walk_rsp_t   expected_walks[$];
  bit          idle_en;
  int          hold_left;
  int          stall_left;
  int          n_errors;
  int          n_sent;
  int          n_checked;
  int          status_seen [0:7];

  sv39_page_table_walker_unit #(.STORE_PAGES(N_PAGES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400_000);
    $display("sv39_page_table_walker_unit_test: done, errors");
    $finish;
  end

  // Walks the tables exactly as the block should and applies any table update.
  function automatic walk_rsp_t walk_predict(input walk_req_t r);
    walk_rsp_t   rsp;
    logic [43:0] page;
    logic [63:0] pte;
    int          slot;
    int          lvl;
    rsp = '0;
    if (r.op == ptw_pkg::OP_WRITE_WORD) begin
      page_store[int'(r.spage) * ptw_pkg::ENTRIES_PER_PAGE + int'(r.sidx)] = r.sdata;
    end else if (r.op <= ptw_pkg::OP_UNMAP) begin
      page = 44'(root_sel);
      if (r.va[38]) begin
        rsp.status = ptw_pkg::STS_ADDR_HIGH;
      end
      for (lvl = 2; lvl > 0 && rsp.status == ptw_pkg::STS_OK; lvl--) begin
        pte = page_store[int'(page) * ptw_pkg::ENTRIES_PER_PAGE +
                         int'(r.va[12 + 9 * lvl +: 9])];
        if (!pte[ptw_pkg::PTE_V_BIT]) begin
          rsp.status = ptw_pkg::STS_NOT_MAPPED;
        end else begin
          page = pte[ptw_pkg::PPN_MSB:ptw_pkg::PPN_LSB];
          if (page >= N_PAGES) begin
            rsp.status = ptw_pkg::STS_TABLE_OOB;
          end
        end
      end
      if (rsp.status == ptw_pkg::STS_OK) begin
        slot = int'(page) * ptw_pkg::ENTRIES_PER_PAGE + int'(r.va[20:12]);
        pte = page_store[slot];
        rsp.leaf = pte;
        case (r.op)
          ptw_pkg::OP_LOOKUP: begin
            rsp.pa = {pte[ptw_pkg::PPN_MSB:ptw_pkg::PPN_LSB], r.va[11:0]};
          end
          ptw_pkg::OP_TR_READ, ptw_pkg::OP_TR_WRITE: begin
            if (!pte[ptw_pkg::PTE_V_BIT]) begin
              rsp.status = ptw_pkg::STS_NOT_MAPPED;
            end else if (!pte[ptw_pkg::PTE_U_BIT] ||
                         (r.op == ptw_pkg::OP_TR_WRITE && !pte[ptw_pkg::PTE_W_BIT])) begin
              rsp.status = ptw_pkg::STS_PERM_DENIED;
            end else begin
              rsp.pa = {pte[ptw_pkg::PPN_MSB:ptw_pkg::PPN_LSB], r.va[11:0]};
            end
          end
          ptw_pkg::OP_MAP: begin
            if (pte[ptw_pkg::PTE_V_BIT] && pte[ptw_pkg::PPN_MSB:ptw_pkg::PPN_LSB] != r.ppn) begin
              rsp.status = ptw_pkg::STS_REMAP;
            end else begin
              rsp.leaf = {10'b0, r.ppn, 5'b0, r.perm, 1'b1};
              page_store[slot] = rsp.leaf;
              rsp.pa = {r.ppn, r.va[11:0]};
            end
          end
          default: begin
            if (!pte[ptw_pkg::PTE_V_BIT]) begin
              rsp.status = ptw_pkg::STS_NOT_MAPPED;
            end else begin
              page_store[slot] = '0;
            end
          end
        endcase
      end
    end
    return rsp;
  endfunction

  function automatic walk_req_t make_req(input logic [2:0] op, input logic [38:0] va,
                                         input logic [43:0] ppn, input logic [3:0] perm,
                                         input logic [2:0] spage, input logic [8:0] sidx,
                                         input logic [63:0] sdata);
    walk_req_t r;
    r.op    = op;
    r.va    = va;
    r.ppn   = ppn;
    r.perm  = perm;
    r.spage = spage;
    r.sidx  = sidx;
    r.sdata = sdata;
    return r;
  endfunction

  function automatic logic [63:0] ptr_word(input logic [43:0] ppn);
    return {10'b0, ppn, 9'b0, 1'b1};
  endfunction

  // A small set of indexes makes table writes and walks land on the same entries.
  function automatic logic [8:0] pick_index();
    case ($urandom_range(0, 12))
      0, 1:    return 9'd0;
      2, 3:    return 9'd1;
      4, 5:    return 9'd37;
      6, 7:    return 9'd255;
      8, 9:    return 9'd300;
      10, 11:  return 9'd511;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [38:0] pick_va();
    logic [8:0] top;
    top = pick_index();
    if ($urandom_range(0, 19) != 0) begin
      top[8] = 1'b0;
    end
    return {top, pick_index(), pick_index(), 12'($urandom)};
  endfunction

  function automatic logic [63:0] table_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: w[ptw_pkg::PTE_V_BIT] = 1'b0;
      1: w[ptw_pkg::PTE_V_BIT] = 1'b1;
      default: begin
        w[ptw_pkg::PPN_MSB:ptw_pkg::PPN_LSB] = 44'($urandom_range(0, N_PAGES - 1));
        w[ptw_pkg::PTE_V_BIT] = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic walk_req_t random_item();
    walk_req_t    r;
    logic [191:0] noise;
    int           pick;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(walk_req_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      r.va = pick_va();
    end
    if (pick < 25) begin
      r.op = ptw_pkg::OP_WRITE_WORD;
      r.sidx = pick_index();
      r.sdata = table_word();
    end else if (pick < 40) begin
      r.op = ptw_pkg::OP_MAP;
      if ($urandom_range(0, 3) != 0) begin
        r.ppn = 44'($urandom_range(0, 15));
      end
    end else if (pick < 65) begin
      r.op = $urandom_range(0, 1) ? ptw_pkg::OP_TR_WRITE : ptw_pkg::OP_TR_READ;
    end else if (pick < 75) begin
      r.op = ptw_pkg::OP_LOOKUP;
    end else if (pick < 85) begin
      r.op = ptw_pkg::OP_UNMAP;
    end
    return r;
  endfunction

  task automatic send_item(input walk_req_t r);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ptw_pkg::IN_DATA_W'(r);
    do @(posedge clk); while (!in_tready);
    expected_walks.push_back(walk_predict(r));
    n_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_walks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_root(input logic [2:0] page);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= page;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    root_sel = page;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(random_item());
  endtask

  task automatic test_reset_state();
    set_root(3'd0);
    send_item(make_req(ptw_pkg::OP_LOOKUP, '0, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_TR_WRITE, '0, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_LOOKUP, '1, '1, '1, '1, '1, '1));
    send_item(make_req(3'd6, '1, '1, '1, '1, '1, '1));
    send_item(make_req(3'd7, '0, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_WRITE_WORD, '0, '0, '0, 3'd7, 9'd511, '1));
  endtask

  task automatic test_directed_walk();
    logic [38:0] va;
    logic [43:0] top_ppn;
    va = {9'd5, 9'd6, 9'd7, 12'habc};
    top_ppn = '1;
    send_item(make_req(ptw_pkg::OP_WRITE_WORD, '0, '0, '0, 3'd0, 9'd5, ptr_word(44'd1)));
    send_item(make_req(ptw_pkg::OP_TR_READ, va, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_WRITE_WORD, '0, '0, '0, 3'd1, 9'd6, ptr_word(44'd2)));
    // An invalid leaf still gives a lookup result.
    send_item(make_req(ptw_pkg::OP_LOOKUP, va, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_TR_READ, va, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_UNMAP, va, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_MAP, va, top_ppn, 4'b0001, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_TR_READ, va, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_MAP, va, top_ppn, 4'b1001, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_TR_READ, va, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_TR_WRITE, va, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_MAP, va, top_ppn, 4'b1111, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_TR_WRITE, va, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_MAP, va, '0, 4'b1111, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_UNMAP, va, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_UNMAP, va, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_MAP, va, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_WRITE_WORD, '0, '0, '0, 3'd1, 9'd6, ptr_word(top_ppn)));
    send_item(make_req(ptw_pkg::OP_TR_READ, va, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_WRITE_WORD, '0, '0, '0, 3'd0, 9'd5, ptr_word(44'd8)));
    send_item(make_req(ptw_pkg::OP_LOOKUP, va, '0, '0, '0, '0, '0));
    send_item(make_req(ptw_pkg::OP_WRITE_WORD, '0, '0, '0, 3'd0, 9'd5, '0));
    send_item(make_req(ptw_pkg::OP_LOOKUP, va, '0, '0, '0, '0, '0));
  endtask

  task automatic test_root_settings();
    set_root(3'd7);
    send_random(60);
    set_root(3'd3);
    send_random(60);
    set_root(3'd0);
    send_random(60);
  endtask

  // The sink holds off long enough that the block backs up and drops in_tready.
  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_left = 400;
    send_random(40);
    idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    set_root(3'd2);
    send_random(180);
    set_root(3'd7);
    send_random(180);
    set_root(3'd5);
    send_random(180);
    set_root(3'd1);
    send_random(180);
    idle_en = 1'b0;
    set_root(3'd0);
    send_random(130);
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    idle_en     = 1'b1;
    hold_left   = 0;
    stall_left  = 0;
    n_errors    = 0;
    n_sent      = 0;
    n_checked   = 0;
    root_sel    = '0;
    foreach (page_store[i]) page_store[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed_walk();
    test_root_settings();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    $display("covered %0d transactions over several root pages with stalls, %0d results checked",
             n_sent, n_checked);
    $display("outcomes: ok %0d, high address %0d, not mapped %0d, denied %0d,",
             status_seen[ptw_pkg::STS_OK], status_seen[ptw_pkg::STS_ADDR_HIGH],
             status_seen[ptw_pkg::STS_NOT_MAPPED], status_seen[ptw_pkg::STS_PERM_DENIED]);
    $display("          conflict %0d, outside %0d",
             status_seen[ptw_pkg::STS_REMAP], status_seen[ptw_pkg::STS_TABLE_OOB]);
    if (n_errors == 0) begin
      $display("sv39_page_table_walker_unit_test: done, clean");
    end else begin
      $display("sv39_page_table_walker_unit_test: done, errors");
    end
    $finish;
  end

  // Result sink: long hold-offs take priority over short random stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 8);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    walk_rsp_t got;
    walk_rsp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(walk_rsp_t)-1:0];
      n_checked++;
      if (!$isunknown(got.status)) begin
        status_seen[got.status]++;
      end
      if (expected_walks.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("unexpected result transaction: status %0d phys_addr %h leaf_entry %h",
                   got.status, got.pa, got.leaf);
        end
      end else begin
        want = expected_walks.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("mismatch: status exp %0d got %0d, phys_addr exp %h got %h,",
                     want.status, got.status, want.pa, got.pa);
            $display("          leaf_entry exp %h got %h", want.leaf, got.leaf);
          end
        end
      end
    end
  end

endmodule

[sim.f]
rtl/ptw_pkg.sv
rtl/ptw_ram.sv
rtl/sv39_page_table_walker_unit.sv
tb/sv/sv39_page_table_walker_unit_test.sv
